// ===== src/obc_pkg.sv =====
// obc_pkg: shared constants and types for the optimal search tree cost block
// no dependencies
`timescale 1ns / 1ps

package obc_pkg;

   // default and field widths
   localparam int MAX_KEYS_DEF = 16;
   localparam int IDX_W        = 5;
   localparam int WGT_W        = 16;
   localparam int COST_W       = 32;
   // candidate sum: one weight plus two costs and two weight sums
   localparam int CAND_W       = COST_W + 2;

   typedef logic [IDX_W-1:0]  index_type;
   typedef logic [WGT_W-1:0]  weight_type;
   typedef logic [COST_W-1:0] cost_type;
   typedef logic [CAND_W-1:0] cand_type;

endpackage

// ===== src/obc_ram.sv =====
// obc_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module obc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 17
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/optimal_bst_cost.sv =====
// optimal_bst_cost: top level, weight loading and table walk sequencer
// depends on obc_pkg and obc_ram
// throughput: one item per cycle while loading, none during the table walk
// reset: synchronous, clears the sequencer and the result valid; rams are not cleared
`timescale 1ns / 1ps

module optimal_bst_cost #(
   parameter int MAX_KEYS = obc_pkg::MAX_KEYS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  obc_pkg::index_type   req_index,
   input  obc_pkg::weight_type  req_key_weight,
   input  obc_pkg::weight_type  req_gap_weight,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output obc_pkg::cost_type    rsp_expected_cost
);

   import obc_pkg::*;

   localparam int KDEPTH = MAX_KEYS + 1;
   localparam int KW     = $clog2(KDEPTH);
   localparam int TDEPTH = (MAX_KEYS + 2) * (MAX_KEYS + 1);
   localparam int AW     = $clog2(TDEPTH);
   localparam int CW     = $clog2(MAX_KEYS + 2);
   localparam int WSW    = WGT_W + $clog2(2 * MAX_KEYS + 2);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_INIT_RD = 4'd1;
   localparam logic [3:0] ST_INIT_WR = 4'd2;
   localparam logic [3:0] ST_ROW_RD  = 4'd3;
   localparam logic [3:0] ST_ROW_WR  = 4'd4;
   localparam logic [3:0] ST_RA      = 4'd5;
   localparam logic [3:0] ST_RB      = 4'd6;
   localparam logic [3:0] ST_CMP     = 4'd7;
   localparam logic [3:0] ST_WR      = 4'd8;
   localparam logic [3:0] ST_FIN_RD  = 4'd9;
   localparam logic [3:0] ST_FIN     = 4'd10;

   logic [3:0]     state_ff, state_in;
   logic [CW-1:0]  n_ff, n_in, i_ff, i_in, j_ff, j_in, r_ff, r_in, len_ff, len_in;
   logic [WSW-1:0] wrun_ff, wrun_in;
   cand_type       acc_ff, acc_in, best_ff, best_in;
   logic           rsp_valid_ff, rsp_valid_in;
   cost_type       rsp_cost_ff, rsp_cost_in;

   logic                     st_we;
   logic [KW-1:0]            st_wa, st_ra;
   logic [2*WGT_W-1:0]       st_wd, st_rd;
   logic                     w_we, e_we;
   logic [AW-1:0]            t_wa, t_ra;
   logic [WSW-1:0]           w_wd, w_rd;
   cost_type                 e_wd, e_rd;
   weight_type               key_rd, gap_rd;
   cand_type                 cand;
   logic                     idx_ok, accept;

   // flat table address of entry (i, j)
   function automatic logic [AW-1:0] taddr(input logic [CW-1:0] ti, input logic [CW-1:0] tj);
      taddr = AW'(32'(ti) * 32'(MAX_KEYS + 1) + 32'(tj));
   endfunction

   assign accept = req_valid && req_ready;
   assign idx_ok = 32'(req_index) <= 32'(MAX_KEYS);
   assign key_rd = st_rd[2*WGT_W-1:WGT_W];
   assign gap_rd = st_rd[WGT_W-1:0];

   // weight store: load port and sequencer read
   assign st_we = accept && idx_ok;
   assign st_wa = KW'(req_index);
   assign st_wd = {(req_index == '0) ? '0 : req_key_weight, req_gap_weight};

   obc_ram #(.WIDTH(2 * WGT_W), .DEPTH(KDEPTH)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   obc_ram #(.WIDTH(WSW), .DEPTH(TDEPTH)) u_wsum (
      .clock(clock), .wr_en(w_we), .wr_addr(t_wa), .wr_data(w_wd),
      .rd_addr(t_ra), .rd_data(w_rd)
   );

   obc_ram #(.WIDTH(COST_W), .DEPTH(TDEPTH)) u_cost (
      .clock(clock), .wr_en(e_we), .wr_addr(t_wa), .wr_data(e_wd),
      .rd_addr(t_ra), .rd_data(e_rd)
   );

   // candidate cost: left part in acc plus right subtree
   assign cand = acc_ff + CAND_W'(e_rd) + CAND_W'(w_rd);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      len_in       = len_ff;
      wrun_in      = wrun_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cost_in  = rsp_cost_ff;
      st_ra        = '0;
      t_ra         = taddr(CW'(1), n_ff);
      t_wa         = taddr(i_ff, j_ff);
      w_we         = 1'b0;
      e_we         = 1'b0;
      w_wd         = wrun_ff;
      e_wd         = best_ff[COST_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               n_in     = idx_ok ? CW'(req_index) : CW'(MAX_KEYS);
               i_in     = CW'(1);
               state_in = ST_INIT_RD;
            end
         end
         ST_INIT_RD: begin
            st_ra    = KW'(i_ff - CW'(1));
            state_in = ST_INIT_WR;
         end
         // diagonal entries take the gap weight
         ST_INIT_WR: begin
            t_wa    = taddr(i_ff, i_ff - CW'(1));
            w_wd    = WSW'(gap_rd);
            e_wd    = COST_W'(gap_rd);
            w_we    = 1'b1;
            e_we    = 1'b1;
            wrun_in = WSW'(gap_rd);
            j_in    = i_ff;
            if (i_ff <= n_ff) begin
               state_in = ST_ROW_RD;
            end else begin
               len_in = CW'(1);
               i_in   = CW'(1);
               j_in   = CW'(1);
               r_in   = CW'(1);
               state_in = (n_ff == '0) ? ST_FIN_RD : ST_RA;
            end
         end
         ST_ROW_RD: begin
            st_ra    = KW'(j_ff);
            state_in = ST_ROW_WR;
         end
         // running weight sum along the row
         ST_ROW_WR: begin
            wrun_in = wrun_ff + WSW'(key_rd) + WSW'(gap_rd);
            w_wd    = wrun_in;
            w_we    = 1'b1;
            if (j_ff == n_ff) begin
               i_in     = i_ff + CW'(1);
               state_in = ST_INIT_RD;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = ST_ROW_RD;
            end
         end
         ST_RA: begin
            t_ra     = taddr(i_ff, r_ff - CW'(1));
            st_ra    = KW'(r_ff);
            state_in = ST_RB;
         end
         ST_RB: begin
            acc_in   = CAND_W'(key_rd) + CAND_W'(e_rd) + CAND_W'(w_rd);
            t_ra     = taddr(r_ff + CW'(1), j_ff);
            state_in = ST_CMP;
         end
         // keep the cheapest root
         ST_CMP: begin
            if (r_ff == i_ff || cand < best_ff) begin
               best_in = cand;
            end
            if (r_ff == j_ff) begin
               state_in = ST_WR;
            end else begin
               r_in     = r_ff + CW'(1);
               state_in = ST_RA;
            end
         end
         ST_WR: begin
            e_we = 1'b1;
            if (j_ff == n_ff) begin
               if (len_ff == n_ff) begin
                  state_in = ST_FIN_RD;
               end else begin
                  len_in   = len_ff + CW'(1);
                  i_in     = CW'(1);
                  j_in     = len_ff + CW'(1);
                  r_in     = CW'(1);
                  state_in = ST_RA;
               end
            end else begin
               i_in     = i_ff + CW'(1);
               j_in     = j_ff + CW'(1);
               r_in     = i_ff + CW'(1);
               state_in = ST_RA;
            end
         end
         ST_FIN_RD: begin
            state_in = ST_FIN;
         end
         // hand over once the output register is free
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = e_rd;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      r_ff        <= r_in;
      len_ff      <= len_in;
      wrun_ff     <= wrun_in;
      acc_ff      <= acc_in;
      best_ff     <= best_in;
      rsp_cost_ff <= rsp_cost_in;
   end

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expected_cost = rsp_cost_ff;

endmodule

// ===== src/obc_checker.sv =====
// obc_checker: port level assertions for optimal_bst_cost, bound to the top level
// depends on obc_pkg
`timescale 1ns / 1ps

module obc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input obc_pkg::cost_type   rsp_expected_cost
);

   import obc_pkg::*;

   // a waiting result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expected_cost))
      else $error("result item changed while stalled");

   // a last item starts the table walk
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("ready after last item");

   // other items only load
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last |=> req_ready)
      else $error("busy after load item");

   // a result appears only at the end of a walk
   a_rsp_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item without a walk");

endmodule

bind optimal_bst_cost obc_checker u_obc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_last(req_last), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_expected_cost(rsp_expected_cost)
);

// ===== test/tb.sv =====
// tb: self-checking testbench for optimal_bst_cost
// depends on obc_pkg and the optimal_bst_cost rtl; holds its own cost predictor
`timescale 1ns / 1ps

module tb;
   import obc_pkg::*;

   localparam int NKEYS = MAX_KEYS_DEF;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   index_type  req_index = '0;
   weight_type req_key_weight = '0;
   weight_type req_gap_weight = '0;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   cost_type   rsp_expected_cost;

   // predictor copy of the weight stores and which entries hold data
   weight_type key_copy [0:NKEYS];
   weight_type gap_copy [0:NKEYS];
   bit         loaded   [0:NKEYS];
   cost_type   cost_queue[$];

   int  errors = 0;
   int  items_sent = 0;
   int  costs_checked = 0;
   int  ready_hold = 0;
   bit  ready_free = 1'b0;

   optimal_bst_cost u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_index(req_index), .req_key_weight(req_key_weight),
      .req_gap_weight(req_gap_weight), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_expected_cost(rsp_expected_cost)
   );

   always #2 clock = ~clock;

   // minimum expected search cost over keys 1..n from the stored weights
   function automatic cost_type min_tree_cost(input int n);
      longint unsigned wsum [0:NKEYS+1][0:NKEYS];
      longint unsigned cost [0:NKEYS+1][0:NKEYS];
      longint unsigned best, cand;
      int j;
      for (int i = 1; i <= n + 1; i++) begin
         wsum[i][i-1] = gap_copy[i-1];
         cost[i][i-1] = gap_copy[i-1];
         for (int k = i; k <= n; k++)
            wsum[i][k] = wsum[i][k-1] + key_copy[k] + gap_copy[k];
      end
      for (int len = 1; len <= n; len++) begin
         for (int i = 1; i + len - 1 <= n; i++) begin
            j = i + len - 1;
            best = 0;
            for (int r = i; r <= j; r++) begin
               cand = key_copy[r] + cost[i][r-1] + wsum[i][r-1]
                      + cost[r+1][j] + wsum[r+1][j];
               if (r == i || cand < best) best = cand;
            end
            cost[i][j] = best & 64'hFFFF_FFFF;
         end
      end
      return cost_type'(cost[1][n]);
   endfunction

   // result side stalls: short random drops and a few long holds, none while ready_free is set
   always @(posedge clock) begin
      if (ready_free) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold = ready_hold - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
         ready_hold = $urandom_range(5, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // compare each accepted result with the oldest expected cost
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cost_queue.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_expected_cost);
            errors++;
         end else begin
            if (rsp_expected_cost !== cost_queue[0]) begin
               $display("%0t: expected_cost mismatch, expected %h actual %h",
                        $time, cost_queue[0], rsp_expected_cost);
               errors++;
            end
            void'(cost_queue.pop_front());
            costs_checked++;
         end
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic weight_type pick_weight();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return weight_type'($urandom);
   endfunction

   // send one item and update the predictor once it is accepted
   task automatic send_item(input int idx, input weight_type kw, input weight_type gw,
                            input bit last);
      int gap;
      int n;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_index      <= index_type'(idx);
      req_key_weight <= kw;
      req_gap_weight <= gw;
      req_last       <= last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (idx <= NKEYS) begin
         key_copy[idx] = (idx == 0) ? '0 : kw;
         gap_copy[idx] = gw;
         loaded[idx]   = 1'b1;
      end
      if (last) begin
         n = (idx > NKEYS) ? NKEYS : idx;
         cost_queue = {cost_queue, min_tree_cost(n)};
      end
   endtask

   // full load of indexes 0..n-1 in shuffled order (noisy mixes in dropped items), closed by last at n or beyond
   task automatic send_tree(input int n, input bit noisy, input bit top);
      int order[$];
      int pick, tmp;
      for (int k = 0; k < n; k++) order = {order, k};
      for (int k = order.size() - 1; k > 0; k--) begin
         pick = $urandom_range(0, k);
         tmp = order[k]; order[k] = order[pick]; order[pick] = tmp;
      end
      foreach (order[k]) begin
         if (noisy && $urandom_range(0, 7) == 0)
            send_item($urandom_range(NKEYS + 1, 31), pick_weight(), pick_weight(), 1'b0);
         send_item(order[k], pick_weight(), pick_weight(), 1'b0);
      end
      send_item(top ? $urandom_range(NKEYS + 1, 31) : n, pick_weight(), pick_weight(), 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cost_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // empty tree: cost is the single gap weight, key weight at index 0 ignored
   task automatic test_empty_tree();
      send_item(0, 16'hFFFF, 16'hFFFF, 1'b1);
      send_item(0, 16'h1234, 16'h0000, 1'b1);
      send_item(0, 16'h0000, 16'hA5A5, 1'b1);
   endtask

   // extremes of the weights, one key and the full key count
   task automatic test_weight_extremes();
      send_item(0, 16'h0000, 16'hFFFF, 1'b0);
      send_item(1, 16'hFFFF, 16'hFFFF, 1'b1);
      for (int k = 0; k < NKEYS; k++) send_item(k, 16'hFFFF, 16'hFFFF, 1'b0);
      send_item(NKEYS, 16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   // index beyond MAX_KEYS is dropped; a last beyond it saturates the count
   task automatic test_out_of_range();
      send_item(31, 16'h0000, 16'h0000, 1'b0);
      send_item(17, 16'h5555, 16'hAAAA, 1'b1);
      send_item(31, 16'hFFFF, 16'hFFFF, 1'b1);
   endtask

   // stores keep their contents: a sparse reload reuses old entries
   task automatic test_reuse();
      send_item(2, 16'h0001, 16'h0000, 1'b0);
      send_item(5, 16'h0000, 16'h8000, 1'b1);
      send_item(3, 16'h0000, 16'h0000, 1'b1);
   endtask

   // random trees, mostly small, with sparse reloads and dropped items mixed in
   task automatic test_random_trees();
      int kind, n, hi;
      while (items_sent < 950) begin
         kind = $urandom_range(0, 99);
         if (kind < 15) ready_free = ($urandom_range(0, 3) == 0);
         if (kind < 70) begin
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6)
                                           : $urandom_range(7, NKEYS);
            send_tree(n, $urandom_range(0, 1), n == NKEYS && $urandom_range(0, 1));
         end else if (kind < 88) begin
            // sparse reload: last index limited to a fully loaded prefix
            hi = 0;
            while (hi < NKEYS && loaded[hi]) hi++;
            repeat ($urandom_range(0, 3))
               send_item($urandom_range(0, hi - 1), pick_weight(), pick_weight(), 1'b0);
            send_item($urandom_range(0, hi), pick_weight(), pick_weight(), 1'b1);
         end else begin
            repeat ($urandom_range(1, 4))
               send_item($urandom_range(NKEYS + 1, 31), pick_weight(), pick_weight(), 1'b0);
         end
      end
      ready_free = 1'b0;
   endtask

   initial begin
      foreach (loaded[k]) loaded[k] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tree();
      test_weight_extremes();
      test_out_of_range();
      test_reuse();
      wait_drained();
      test_random_trees();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("sent %0d items, checked %0d tree costs (0..%0d keys, dropped and reused entries)",
               items_sent, costs_checked, NKEYS);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #40ms;
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
